// File: sv/bcu_pkg.sv
// bcu_pkg: widths and limits shared by the binomial coefficient unit
// no dependencies; used by bcu_mul, bcu_div and binomial_coefficient_unit_top
package bcu_pkg;

   localparam int unsigned ACC_W = 32;
   localparam int unsigned OPD_W = 8;
   localparam int unsigned LIM_W = 16;

   localparam logic [LIM_W-1:0] MAX_TOTAL = 16'd255;

   localparam logic [ACC_W-1:0] COEF_ZERO = 32'd0;
   localparam logic [ACC_W-1:0] COEF_ONE  = 32'd1;

endpackage

// File: sv/bcu_mul.sv
// bcu_mul: bit-serial shift-and-add multiplier, 32-bit operand by 8-bit operand
// keeps the low 32 bits of the product; depends on bcu_pkg
module bcu_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bcu_pkg::ACC_W-1:0]   multiplicand,
   input  logic [bcu_pkg::OPD_W-1:0]   multiplier,
   output logic                        done,
   output logic [bcu_pkg::ACC_W-1:0]   product
);

   localparam int unsigned CNT_W = $clog2(bcu_pkg::OPD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bcu_pkg::OPD_W - 1);

   logic [bcu_pkg::ACC_W-1:0] mcand_ff;
   logic [bcu_pkg::OPD_W-1:0] mplier_ff;
   logic [bcu_pkg::ACC_W-1:0] prod_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      run_ff;
   logic                      done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mcand_ff  <= multiplicand;
            mplier_ff <= multiplier;
            prod_ff   <= '0;
            count_ff  <= '0;
            run_ff    <= 1'b1;
         end else if (run_ff) begin
            if (mplier_ff[0]) begin
               prod_ff <= prod_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[bcu_pkg::ACC_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[bcu_pkg::OPD_W-1:1]};
            count_ff  <= count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// File: sv/bcu_div.sv
// bcu_div: restoring divider, one quotient bit per cycle, 32-bit by 8-bit
// floor quotient only; depends on bcu_pkg
module bcu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bcu_pkg::ACC_W-1:0]   dividend,
   input  logic [bcu_pkg::OPD_W-1:0]   divisor,
   output logic                        done,
   output logic [bcu_pkg::ACC_W-1:0]   quotient
);

   localparam int unsigned CNT_W = $clog2(bcu_pkg::ACC_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bcu_pkg::ACC_W - 1);

   logic [bcu_pkg::ACC_W-1:0] quot_ff;
   logic [bcu_pkg::OPD_W-1:0] rem_ff;
   logic [bcu_pkg::OPD_W-1:0] dsor_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      run_ff;
   logic                      done_ff;
   logic [bcu_pkg::OPD_W:0]   trial;
   logic [bcu_pkg::OPD_W:0]   diff;
   logic                      fits;

   always_comb begin
      trial = {rem_ff, quot_ff[bcu_pkg::ACC_W-1]};
      diff  = trial - {1'b0, dsor_ff};
      fits  = (trial >= {1'b0, dsor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff  <= dividend;
            rem_ff   <= '0;
            dsor_ff  <= divisor;
            count_ff <= '0;
            run_ff   <= 1'b1;
         end else if (run_ff) begin
            if (fits) begin
               rem_ff  <= diff[bcu_pkg::OPD_W-1:0];
               quot_ff <= {quot_ff[bcu_pkg::ACC_W-2:0], 1'b1};
            end else begin
               rem_ff  <= trial[bcu_pkg::OPD_W-1:0];
               quot_ff <= {quot_ff[bcu_pkg::ACC_W-2:0], 1'b0};
            end
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: sv/binomial_coefficient_unit_top.sv
// binomial_coefficient_unit_top: n choose k by the multiplicative method
// depends on bcu_pkg, bcu_mul and bcu_div
//
// A request is transferred when start is high and busy is low; its result appears on
// rsp_coefficient for exactly one cycle with rsp_valid high and cannot be held off.
// If k exceeds n the result is 0, if k is 0 or equals n it is 1, and either comes the
// cycle after the transfer with busy staying low. Otherwise k is reduced to
// m = min(k, n-k) and m steps run, each a bit-serial multiply by (n-i) that keeps the
// low 32 bits, then a bit-serial divide by (i+1). Each unit is started by a registered
// start pulse and its done pulse hands over to the other unit; the result of the last
// divide is registered and transferred, and busy stays high from the transfer of the
// request until the result appears.
module binomial_coefficient_unit_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bcu_pkg::OPD_W-1:0]         req_total_items,
   input  logic [bcu_pkg::OPD_W-1:0]         req_chosen_items,
   output logic                              rsp_valid,
   output logic [bcu_pkg::ACC_W-1:0]         rsp_coefficient
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type                 state_ff, state_in;
   logic [bcu_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [bcu_pkg::OPD_W-1:0] idx_ff, idx_in;
   logic [bcu_pkg::OPD_W-1:0] total_ff, total_in;
   logic [bcu_pkg::OPD_W-1:0] choose_ff, choose_in;
   logic                      mul_start_ff, mul_start_in;
   logic                      div_start_ff, div_start_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bcu_pkg::ACC_W-1:0] rsp_coef_ff, rsp_coef_in;

   logic                      accept;
   logic [bcu_pkg::OPD_W-1:0] rest;
   logic [bcu_pkg::OPD_W-1:0] idx_next;
   logic                      mul_done;
   logic                      div_done;
   logic [bcu_pkg::ACC_W-1:0] mul_product;
   logic [bcu_pkg::ACC_W-1:0] div_quotient;

   bcu_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start_ff),
      .multiplicand (acc_ff),
      .multiplier   (total_ff - idx_ff),
      .done         (mul_done),
      .product      (mul_product)
   );

   bcu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (mul_product),
      .divisor  (idx_next),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      accept   = start && (state_ff == ST_IDLE);
      rest     = req_total_items - req_chosen_items;
      idx_next = idx_ff + 1'b1;

      state_in     = state_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      choose_in    = choose_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_coef_in  = rsp_coef_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               total_in = req_total_items;
               idx_in   = '0;
               if ({8'd0, req_total_items} > bcu_pkg::MAX_TOTAL
                   || req_chosen_items > req_total_items) begin
                  choose_in    = req_chosen_items;
                  acc_in       = bcu_pkg::COEF_ZERO;
                  rsp_valid_in = 1'b1;
                  rsp_coef_in  = bcu_pkg::COEF_ZERO;
               end else if (req_chosen_items == '0
                            || req_chosen_items == req_total_items) begin
                  choose_in    = req_chosen_items;
                  acc_in       = bcu_pkg::COEF_ONE;
                  rsp_valid_in = 1'b1;
                  rsp_coef_in  = bcu_pkg::COEF_ONE;
               end else begin
                  choose_in    = (req_chosen_items > rest) ? rest : req_chosen_items;
                  acc_in       = bcu_pkg::COEF_ONE;
                  mul_start_in = 1'b1;
                  state_in     = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start_in = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               acc_in = div_quotient;
               idx_in = idx_next;
               if (idx_next == choose_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_coef_in  = div_quotient;
                  state_in     = ST_IDLE;
               end else begin
                  mul_start_in = 1'b1;
                  state_in     = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         idx_ff       <= '0;
         total_ff     <= '0;
         choose_ff    <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         choose_ff    <= choose_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_coef_ff <= rsp_coef_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coef_ff;

`ifndef SYNTHESIS
   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result transfer while busy");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   a_k_above_n_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_chosen_items > req_total_items)
      |=> (rsp_valid && rsp_coefficient == bcu_pkg::COEF_ZERO))
      else $error("k above n did not give zero next cycle");

   a_step_within_choose: assert property (@(posedge clock) disable iff (reset)
      busy |-> (idx_ff < choose_ff))
      else $error("step index ran past the reduced k");
`endif

endmodule

// File: test/binomial_coefficient_unit_top_test.sv
// binomial_coefficient_unit_top_test: self-checking bench for n choose k with 32-bit wrapping
// depends on bcu_pkg and binomial_coefficient_unit_top; a directed table, then random requests
// checked against a local prediction, with random gaps between transfers
module binomial_coefficient_unit_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 118;
   localparam int DIRECTED_ROWS  = 22;
   localparam int QUIET_LIMIT    = 25000;
   localparam int DRAIN_CYCLES   = 100;

   typedef struct {
      logic [bcu_pkg::OPD_W-1:0] total;
      logic [bcu_pkg::OPD_W-1:0] chosen;
      bit                        known;
      logic [bcu_pkg::ACC_W-1:0] coefficient;
   } directed_row_type;

   typedef struct {
      logic [bcu_pkg::ACC_W-1:0] running;
      logic [bcu_pkg::OPD_W-1:0] steps;
      logic [bcu_pkg::OPD_W-1:0] total;
      logic [bcu_pkg::OPD_W-1:0] reduced;
   } choose_state_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [bcu_pkg::OPD_W-1:0] req_total_items  = '0;
   logic [bcu_pkg::OPD_W-1:0] req_chosen_items = '0;
   logic                      rsp_valid;
   logic [bcu_pkg::ACC_W-1:0] rsp_coefficient;

   logic [bcu_pkg::ACC_W-1:0] pending_coefficients [$];
   choose_state_type          last_choose = '{default: '0};
   int                        mismatch_count = 0;
   int                        quiet_cycles = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'd0,   8'd0,   1'b1, bcu_pkg::COEF_ONE},
      '{8'd0,   8'd255, 1'b1, bcu_pkg::COEF_ZERO},
      '{8'd255, 8'd0,   1'b1, bcu_pkg::COEF_ONE},
      '{8'd255, 8'd255, 1'b1, bcu_pkg::COEF_ONE},
      '{8'd254, 8'd255, 1'b1, bcu_pkg::COEF_ZERO},
      '{8'd1,   8'd0,   1'b1, bcu_pkg::COEF_ONE},
      '{8'd1,   8'd1,   1'b1, bcu_pkg::COEF_ONE},
      '{8'd2,   8'd1,   1'b1, 32'd2},
      '{8'd10,  8'd3,   1'b1, 32'd120},
      '{8'd10,  8'd7,   1'b1, 32'd120},
      '{8'd255, 8'd1,   1'b1, 32'd255},
      '{8'd255, 8'd254, 1'b1, 32'd255},
      '{8'd52,  8'd5,   1'b1, 32'd2598960},
      '{8'd85,  8'd170, 1'b1, bcu_pkg::COEF_ZERO},
      '{8'd20,  8'd10,  1'b0, '0},
      '{8'd35,  8'd17,  1'b0, '0},
      '{8'd40,  8'd20,  1'b0, '0},
      '{8'd64,  8'd32,  1'b0, '0},
      '{8'd128, 8'd64,  1'b0, '0},
      '{8'd170, 8'd85,  1'b0, '0},
      '{8'd255, 8'd127, 1'b0, '0},
      '{8'd255, 8'd128, 1'b0, '0}
   };

   binomial_coefficient_unit_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_total_items  (req_total_items),
      .req_chosen_items (req_chosen_items),
      .rsp_valid        (rsp_valid),
      .rsp_coefficient  (rsp_coefficient)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // multiplicative method, products kept to the low 32 bits before each divide
   function automatic logic [bcu_pkg::ACC_W-1:0] choose_wrapped(
         input logic [bcu_pkg::OPD_W-1:0] n,
         input logic [bcu_pkg::OPD_W-1:0] k);
      logic [bcu_pkg::ACC_W-1:0] running;
      logic [bcu_pkg::ACC_W-1:0] n_wide;
      logic [bcu_pkg::ACC_W-1:0] m_wide;
      logic [bcu_pkg::ACC_W-1:0] step;
      logic [bcu_pkg::OPD_W-1:0] reduced;
      n_wide  = {24'd0, n};
      reduced = k;
      last_choose.total = n;
      last_choose.steps = '0;
      if ({8'd0, n} > bcu_pkg::MAX_TOTAL || k > n) begin
         running = bcu_pkg::COEF_ZERO;
      end else if (k == 0 || k == n) begin
         running = bcu_pkg::COEF_ONE;
      end else begin
         if (k > n - k) begin
            reduced = n - k;
         end
         m_wide  = {24'd0, reduced};
         running = bcu_pkg::COEF_ONE;
         for (step = 0; step < m_wide; step++) begin
            running = running * (n_wide - step);
            running = running / (step + 1);
         end
         last_choose.steps = reduced;
      end
      last_choose.reduced = reduced;
      last_choose.running = running;
      return running;
   endfunction

   task automatic send_request(input logic [bcu_pkg::OPD_W-1:0] n,
                               input logic [bcu_pkg::OPD_W-1:0] k,
                               input int gap, input bit known,
                               input logic [bcu_pkg::ACC_W-1:0] value);
      logic [bcu_pkg::ACC_W-1:0] predicted;
      predicted = choose_wrapped(n, k);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_total_items  <= n;
      req_chosen_items <= k;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      pending_coefficients.push_back(known ? value : predicted);
   endtask

   initial begin
      logic [bcu_pkg::OPD_W-1:0] n;
      logic [bcu_pkg::OPD_W-1:0] k;
      int                        gap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[row]) begin
         gap = (row % 8 < 3) ? 0 : $urandom_range(0, 7);
         send_request(directed_rows[row].total, directed_rows[row].chosen, gap,
                      directed_rows[row].known, directed_rows[row].coefficient);
      end
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         // mostly small n to keep run time short, some full-range pairs
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(0, 255);
            k = $urandom_range(0, 255);
         end else begin
            n = $urandom_range(0, 40);
            k = $urandom_range(0, n + 2);
         end
         gap = (item % 32 < 8) ? 0 : $urandom_range(0, 7);
         send_request(n, k, gap, 1'b0, '0);
      end
      start <= 1'b0;
      while (pending_coefficients.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin : check_results
      logic [bcu_pkg::ACC_W-1:0] expected_coefficient;
      if (!reset && rsp_valid) begin
         if (pending_coefficients.size() == 0) begin
            $display("%0t: unexpected result transfer, coefficient %0d",
                     $time, rsp_coefficient);
            mismatch_count++;
         end else begin
            expected_coefficient = pending_coefficients.pop_front();
            if (rsp_coefficient !== expected_coefficient) begin
               $display("%0t: coefficient mismatch, expected %0d, actual %0d",
                        $time, expected_coefficient, rsp_coefficient);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: filelist.f
sv/bcu_pkg.sv
sv/bcu_mul.sv
sv/bcu_div.sv
sv/binomial_coefficient_unit_top.sv
test/binomial_coefficient_unit_top_test.sv
